FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_top and spq_checker; no dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VAL_W   = 32;
  localparam int PRI_W   = 8;
  localparam int CAP_W   = 7;
  localparam int CNT_O_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // Command broadcast to every cell of the row in the cycle an item is accepted.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } cmd_t;

endpackage

FILE: rtl/core/spq_cell.sv
// One storage cell of the sorted queue row: holds one (value, priority) entry.
// Depends on spq_pkg for the command struct and field widths.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [CW-1:0]    count,
  input  logic [VAL_W-1:0] left_value,
  input  logic [PRI_W-1:0] left_prio,
  input  logic             left_gt,
  input  logic [VAL_W-1:0] right_value,
  input  logic [PRI_W-1:0] right_prio,
  output logic [VAL_W-1:0] value,
  output logic [PRI_W-1:0] prio,
  output logic             gt
);

  logic occ;
  logic is_tail;

  // The cell is occupied when its position lies below the held count.
  assign occ     = count > CW'(IDX);
  assign is_tail = count == CW'(IDX);
  // Strictly greater priority: this entry must move back for the new one.
  assign gt      = occ && (prio > cmd.prio);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_gt) begin
        value <= left_value;
        prio  <= left_prio;
      end else if (gt || is_tail) begin
        value <= cmd.value;
        prio  <= cmd.prio;
      end
    end else if (cmd.rem) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule

FILE: rtl/core/sorted_priority_queue_top.sv
// A result word is registered in the cycle after its input word is accepted.
// One word per cycle unless stalled; the whole cell row shifts in the accept cycle.
// Each cell compares only its own priority and reads its left and right neighbors.
// Reset (synchronous, rst high): count zero, capacity 64, no result pending.
// Entry storage is not cleared; stale entries above the count never reach a result.
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [VAL_W-1:0]   item_value,
  input  logic [PRI_W-1:0]   item_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [VAL_W-1:0]   removed_value,
  output logic [PRI_W-1:0]   removed_priority,
  output logic [CNT_O_W-1:0] entry_count
);

  // The count must reach DEPTH itself; the limit compare also needs room for capacity.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    held_count;
  logic [CW-1:0]    count_next;
  logic [LW-1:0]    limit;
  logic             accept;
  logic             full;
  logic             empty;
  cmd_t             cmd;

  logic [VAL_W-1:0] cell_value [DEPTH];
  logic [PRI_W-1:0] cell_prio  [DEPTH];
  logic             cell_gt    [DEPTH];

  // The output register parts the two sides: a new word is taken whenever the
  // result slot is empty or is being emptied in the same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // The limit in force is the smaller of the capacity register and DEPTH.
  assign limit = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
  assign full  = LW'(held_count) >= limit;
  assign empty = held_count == '0;

  always_comb begin
    cmd.ins   = accept && !func && !full;
    cmd.rem   = accept && func && !empty;
    cmd.value = item_value;
    cmd.prio  = item_priority;
  end

  always_comb begin
    count_next = held_count;
    if (cmd.ins) begin
      count_next = held_count + CW'(1);
    end else if (cmd.rem) begin
      count_next = held_count - CW'(1);
    end
  end

  // Row of cells in ascending priority order; cell 0 is the head. An insert
  // moves every strictly greater entry back one place and drops the new entry
  // into the gap, so ties keep arrival order. A remove shifts the row forward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lv;
    logic [PRI_W-1:0] lp;
    logic             lg;
    logic [VAL_W-1:0] rv;
    logic [PRI_W-1:0] rp;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lp = '0;
      assign lg = 1'b0;
    end else begin : g_inner_l
      assign lv = cell_value[i-1];
      assign lp = cell_prio[i-1];
      assign lg = cell_gt[i-1];
    end

    // The last cell refills with its own entry on remove; it falls out of the
    // occupied range anyway.
    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_value[i];
      assign rp = cell_prio[i];
    end else begin : g_inner_r
      assign rv = cell_value[i+1];
      assign rp = cell_prio[i+1];
    end

    spq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (held_count),
      .left_value  (lv),
      .left_prio   (lp),
      .left_gt     (lg),
      .right_value (rv),
      .right_prio  (rp),
      .value       (cell_value[i]),
      .prio        (cell_prio[i]),
      .gt          (cell_gt[i])
    );
  end

  // Control state, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      held_count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is loaded with every accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count      <= CNT_O_W'(count_next);
      removed_value    <= '0;
      removed_priority <= '0;
      if (!func) begin
        status <= full ? ST_OVERFLOW : ST_INSERTED;
      end else if (empty) begin
        status <= ST_UNDERFLOW;
      end else begin
        status           <= ST_REMOVED;
        removed_value    <= cell_value[0];
        removed_priority <= cell_prio[0];
      end
    end
  end

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checks for sorted_priority_queue_top, attached by bind.
// Depends on spq_pkg for field widths and status codes.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [VAL_W-1:0]   removed_value,
  input logic [PRI_W-1:0]   removed_priority,
  input logic [CNT_O_W-1:0] entry_count
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Underflow only happens on an empty queue and carries no entry.
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |->
      entry_count == '0 && removed_value == '0 && removed_priority == '0)
    else $error("underflow with entries or data");

  // A successful insert always leaves at least one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INSERTED |-> entry_count != '0)
    else $error("insert reported with zero count");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(removed_value) && $stable(entry_count))
    else $error("result changed while stalled");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .removed_value    (removed_value),
  .removed_priority (removed_priority),
  .entry_count      (entry_count)
);
